// ----- sv/mplu_pkg.sv -----
`default_nettype none
package mplu_pkg;

  // Sizes of the ring and of the exponential table
  localparam int SITES_DEF     = 256;
  localparam int EXP_DEPTH_DEF = 256;

  // Field widths
  localparam int POS_W    = 16;
  localparam int SITE_W   = 8;
  localparam int DRAW_W   = 16;
  localparam int COEFF_W  = 24;
  localparam int TOTAL_W  = 48;
  localparam int COUNT_W  = 32;
  localparam int EXP_W    = 17;
  localparam int DELTA_W  = 36;
  localparam int BOND_W   = 33;

  // Shared multiplier
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Configuration registers
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KINETIC   = 2'd0,
    CFG_POTENTIAL = 2'd1,
    CFG_INV_TEMP  = 2'd2
  } cfg_idx_t;

  localparam logic [COEFF_W-1:0] KINETIC_RESET   = 24'd65536;
  localparam logic [COEFF_W-1:0] POTENTIAL_RESET = 24'd32768;
  localparam logic [COEFF_W-1:0] INV_TEMP_RESET  = 24'd65536;

  // Action codes
  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_PROPOSE = 1'b1
  } action_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_RD_C,
    ST_RD_L,
    ST_RD_R,
    ST_NEWX,
    ST_BOND_PREP,
    ST_MUL_DD,
    ST_MUL_SS,
    ST_MUL_KD,
    ST_MUL_PS,
    ST_BOND_SUM,
    ST_BOND_ACC,
    ST_DECIDE,
    ST_EXP_MUL,
    ST_EXP_IDX,
    ST_EXP_RD,
    ST_EXP_CMP,
    ST_COMMIT
  } state_t;

endpackage
`default_nettype wire

// ----- sv/mplu_path_mem.sv -----
`default_nettype none
module mplu_path_mem
  import mplu_pkg::*;
#(
  parameter int DEPTH = SITES_DEF,
  parameter int AW    = $clog2(SITES_DEF)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [POS_W-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [POS_W-1:0] rdata
);

  logic [POS_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/mplu_exp_rom.sv -----
`default_nettype none
module mplu_exp_rom
  import mplu_pkg::*;
#(
  parameter int DEPTH = EXP_DEPTH_DEF,
  parameter int IW    = $clog2(EXP_DEPTH_DEF)
) (
  input  wire logic             clk,
  input  wire logic [IW-1:0]    addr,
  output logic      [EXP_W-1:0] data
);

  // exp(-16*i/DEPTH) in Q1.16: Taylor series of exp(-i/DEPTH) in Q2.30,
  // squared four times, rounded half up
  function automatic logic [EXP_W-1:0] exp_entry(input int unsigned i);
    logic [63:0] u;
    logic [63:0] term;
    logic [63:0] e;
    longint      sum;
    u    = (64'(i) << 30) / 64'(DEPTH);
    sum  = longint'(1) <<< 30;
    term = 64'd1 << 30;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * u) >> 30) / 64'(n);
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    e = (sum < 0) ? 64'd0 : 64'(sum);
    for (int k = 0; k < 4; k++) begin
      e = (e * e) >> 30;
    end
    return EXP_W'((e + 64'd8192) >> 14);
  endfunction

  logic [EXP_W-1:0] tbl [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    localparam logic [EXP_W-1:0] ENTRY = exp_entry(g);
    assign tbl[g] = ENTRY;
  end

  always_ff @(posedge clk) begin
    data <= tbl[addr];
  end

endmodule
`default_nettype wire

// ----- sv/mplu_mul.sv -----
`default_nettype none
module mplu_mul
  import mplu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic      [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= {{MUL_B_W{1'b0}}, a} * {{MUL_A_W{1'b0}}, b};
  end

endmodule
`default_nettype wire

// ----- sv/metropolis_path_lattice_update_unit.sv -----
`default_nettype none
// Channel   Dir  Beat fields (low bit first)
// s_*       in   tuser: action; tdata: site[7:0], value[23:8], uniform_draw[39:24]
// m_*       out  tuser: accepted; tdata: site_value[15:0], total_action[63:16],
//                accept_total[95:64]
// cfg_*     in   cfg_index: register, cfg_data: value (kinetic, potential, inv temp)
//
// One item at a time: a new beat is taken only in the idle state, once the last result is
// in the output register; a site index of SITES or more is first folded onto the ring. The
// multiplier carries 16 bond products per item and one more for the table index; the path
// memory has one read port, so the site and neighbor reads are serial.
// After reset a clearing pass writes zero to every site of the path; s_tready stays low.
// A finished beat waits in the output register; only the commit step waits for it to go.
module metropolis_path_lattice_update_unit
  import mplu_pkg::*;
#(
  parameter int SITES           = SITES_DEF,
  parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [39:0]          s_tdata,  // site, value, uniform_draw
  input  wire logic                 s_tuser,  // action
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [95:0]          m_tdata,  // site_value, total_action, accept_total
  output logic                      m_tuser,  // accepted
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEFF_W-1:0]   cfg_data
);

  localparam int AW   = $clog2(SITES);
  localparam int IDXW = ($clog2(SITES + 1) > SITE_W) ? $clog2(SITES + 1) : SITE_W;
  localparam int EIW  = $clog2(EXP_TABLE_DEPTH);
  localparam int EDW  = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int ARG_W = MUL_P_W - 16;
  localparam int SCL_W = 20 + EDW;
  localparam logic [IDXW-1:0] SITES_I = IDXW'(SITES);
  localparam logic [AW-1:0]   LAST_K  = AW'(SITES - 1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  state_t state, state_next;

  // configuration
  logic [COEFF_W-1:0] kc, pc, itemp;

  // path state
  logic [TOTAL_W-1:0] action_total;
  logic [COUNT_W-1:0] accepted_count;

  // item registers
  action_t             op;
  logic [IDXW-1:0]     idx;
  logic [POS_W-1:0]    val;
  logic [DRAW_W-1:0]   draw;
  logic [POS_W-1:0]    oldx, xl, xr, newx;
  logic [POS_W-1:0]    dabs;
  logic [POS_W:0]      sabs;
  logic [31:0]         sq_d;
  logic [32:0]         sq_s;
  logic [55:0]         kd;
  logic [BOND_W-1:0]   bond;
  logic signed [DELTA_W-1:0] delta;
  logic [1:0]          bond_cnt;
  logic                big;
  logic [EIW-1:0]      exp_idx;
  logic                take;
  logic [AW-1:0]       clr_cnt;

  // datapath wiring
  logic [AW-1:0]       k, left_k, right_k;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  prod;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [POS_W-1:0]    mem_wdata, mem_rdata;
  logic [EXP_W-1:0]    rom_data;
  logic                slot_free;
  logic [POS_W-1:0]    pa, pb;
  logic [POS_W:0]      d17, s17, psum;
  logic [58:0]         bond_sum;
  logic [ARG_W-1:0]    arg;
  logic [SCL_W-1:0]    scaled;
  logic signed [TOTAL_W+1:0] tsum;
  logic [TOTAL_W-1:0]  total_next;
  logic [COUNT_W-1:0]  count_next;

  assign cfg_ready = 1'b1;
  assign slot_free = !m_tvalid || m_tready;

  assign k       = idx[AW-1:0];
  assign left_k  = (k == '0) ? LAST_K : k - AW'(1);
  assign right_k = (k == LAST_K) ? '0 : k + AW'(1);

  mplu_path_mem #(.DEPTH(SITES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mplu_exp_rom #(.DEPTH(EXP_TABLE_DEPTH), .IW(EIW)) u_rom (
    .clk  (clk),
    .addr (exp_idx),
    .data (rom_data)
  );

  mplu_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kc    <= KINETIC_RESET;
      pc    <= POTENTIAL_RESET;
      itemp <= INV_TEMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_KINETIC:   kc    <= cfg_data;
        CFG_POTENTIAL: pc    <= cfg_data;
        CFG_INV_TEMP:  itemp <= cfg_data;
        default:       ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:     if (clr_cnt == LAST_K) state_next = ST_IDLE;
      ST_IDLE:      if (s_tvalid) state_next = ST_REDUCE;
      ST_REDUCE:    if (idx < SITES_I) state_next = ST_RD_C;
      ST_RD_C:      state_next = ST_RD_L;
      ST_RD_L:      state_next = ST_RD_R;
      ST_RD_R:      state_next = ST_NEWX;
      ST_NEWX:      state_next = ST_BOND_PREP;
      ST_BOND_PREP: state_next = ST_MUL_DD;
      ST_MUL_DD:    state_next = ST_MUL_SS;
      ST_MUL_SS:    state_next = ST_MUL_KD;
      ST_MUL_KD:    state_next = ST_MUL_PS;
      ST_MUL_PS:    state_next = ST_BOND_SUM;
      ST_BOND_SUM:  state_next = ST_BOND_ACC;
      ST_BOND_ACC:  state_next = (bond_cnt == 2'd3) ? ST_DECIDE : ST_BOND_PREP;
      ST_DECIDE: begin
        if (op == ACT_LOAD || delta < 0) state_next = ST_COMMIT;
        else state_next = ST_EXP_MUL;
      end
      ST_EXP_MUL:   state_next = ST_EXP_IDX;
      ST_EXP_IDX:   state_next = ST_EXP_RD;
      ST_EXP_RD:    state_next = ST_EXP_CMP;
      ST_EXP_CMP:   state_next = ST_COMMIT;
      ST_COMMIT:    if (slot_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mem_raddr = k;
    mem_we    = 1'b0;
    mem_waddr = k;
    mem_wdata = newx;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_IDLE:   s_tready = 1'b1;
      ST_RD_L:   mem_raddr = left_k;
      ST_RD_R:   mem_raddr = right_k;
      ST_MUL_DD: begin
        mul_a = {18'b0, dabs};
        mul_b = {8'b0, dabs};
      end
      ST_MUL_SS: begin
        mul_a = {17'b0, sabs};
        mul_b = {7'b0, sabs};
      end
      ST_MUL_KD: begin
        mul_a = {2'b0, sq_d};
        mul_b = kc;
      end
      ST_MUL_PS: begin
        mul_a = {1'b0, sq_s};
        mul_b = pc;
      end
      ST_EXP_MUL: begin
        mul_a = delta[MUL_A_W-1:0];
        mul_b = itemp;
      end
      ST_COMMIT: mem_we = take && slot_free;
      default: ;
    endcase
  end

  // bond operands: old left, old right, new left, new right
  always_comb begin
    unique case (bond_cnt)
      2'd0: begin pa = xl;   pb = oldx; end
      2'd1: begin pa = oldx; pb = xr;   end
      2'd2: begin pa = xl;   pb = newx; end
      2'd3: begin pa = newx; pb = xr;   end
      default: begin pa = xl; pb = xr; end
    endcase
  end

  assign d17      = {pa[POS_W-1], pa} - {pb[POS_W-1], pb};
  assign s17      = {pa[POS_W-1], pa} + {pb[POS_W-1], pb};
  assign psum     = {oldx[POS_W-1], oldx} + {val[POS_W-1], val};
  assign bond_sum = {1'b0, kd, 2'b00} + {1'b0, prod};
  assign arg      = prod[MUL_P_W-1:16];
  assign scaled   = SCL_W'(arg[19:0]) * SCL_W'(EXP_TABLE_DEPTH);

  assign tsum = $signed({2'b00, action_total})
              + $signed({{(TOTAL_W + 2 - DELTA_W){delta[DELTA_W-1]}}, delta});

  always_comb begin
    total_next = action_total;
    count_next = accepted_count;
    if (take) begin
      if (tsum < 0) begin
        total_next = '0;
      end else if (tsum[TOTAL_W+1:TOTAL_W] != 2'b00) begin
        total_next = TOTAL_MAX;
      end else begin
        total_next = tsum[TOTAL_W-1:0];
      end
      if (op == ACT_PROPOSE && accepted_count != COUNT_MAX) begin
        count_next = accepted_count + COUNT_W'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_cnt        <= '0;
      bond_cnt       <= '0;
      action_total   <= '0;
      accepted_count <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (state == ST_BOND_ACC) begin
        bond_cnt <= bond_cnt + 2'd1;
      end
      if (state == ST_COMMIT && slot_free) begin
        action_total   <= total_next;
        accepted_count <= count_next;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        op   <= action_t'(s_tuser);
        idx  <= IDXW'(s_tdata[7:0]);
        val  <= s_tdata[23:8];
        draw <= s_tdata[39:24];
      end
      // fold the site index onto the ring
      ST_REDUCE: if (idx >= SITES_I) idx <= idx - SITES_I;
      ST_RD_L:   oldx <= mem_rdata;
      ST_RD_R:   xl   <= mem_rdata;
      ST_NEWX: begin
        xr    <= mem_rdata;
        delta <= '0;
        if (op == ACT_LOAD) begin
          newx <= val;
        end else if (psum[POS_W] != psum[POS_W-1]) begin
          newx <= psum[POS_W] ? 16'h8000 : 16'h7FFF;
        end else begin
          newx <= psum[POS_W-1:0];
        end
      end
      ST_BOND_PREP: begin
        dabs <= d17[POS_W] ? POS_W'(-d17) : d17[POS_W-1:0];
        sabs <= s17[POS_W] ? -s17 : s17;
      end
      ST_MUL_SS:   sq_d <= prod[31:0];
      ST_MUL_KD:   sq_s <= prod[32:0];
      ST_MUL_PS:   kd   <= prod[55:0];
      ST_BOND_SUM: bond <= bond_sum[58:26];
      // add the new bonds, drop the old ones
      ST_BOND_ACC: begin
        if (bond_cnt[1]) begin
          delta <= delta + $signed({3'b000, bond});
        end else begin
          delta <= delta - $signed({3'b000, bond});
        end
      end
      ST_DECIDE: take <= 1'b1;
      ST_EXP_IDX: begin
        big     <= |arg[ARG_W-1:20];
        exp_idx <= scaled[20 +: EIW];
      end
      ST_EXP_CMP: take <= !big && ({1'b0, draw} < rom_data);
      ST_COMMIT: begin
        if (slot_free) begin
          m_tuser        <= take;
          m_tdata[15:0]  <= take ? newx : oldx;
          m_tdata[63:16] <= total_next;
          m_tdata[95:64] <= count_next;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> accepted_count >= $past(accepted_count))
    else $error("accept count went down");

  a_load_accepted: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT && slot_free && op == ACT_LOAD) |=> (m_tvalid && m_tuser))
    else $error("load not reported as accepted");

  a_reject_holds_total: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT && slot_free && !take)
      |=> (action_total == $past(action_total) && accepted_count == $past(accepted_count)))
    else $error("rejected proposal changed the path state");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!s_tready && mem_we && mem_wdata == '0))
    else $error("clearing pass overlapped input");

  a_bonds_complete: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE) |-> (bond_cnt == 2'd0 && $past(state) == ST_BOND_ACC))
    else $error("decision taken before all four bonds");
`endif

endmodule
`default_nettype wire

// ----- sim/metropolis_path_lattice_update_unit_tb.sv -----
`timescale 1ns / 100ps

module metropolis_path_lattice_update_unit_tb;
  import mplu_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] site_value;
    logic [47:0] total_action;
    logic [31:0] accept_total;
  } lattice_outcome_t;

  localparam int   RING_SIZE      = 256;
  localparam int   EXP_ENTRIES    = 256;
  localparam u64_t ACTION_CEIL    = 64'hFFFF_FFFF_FFFF;
  localparam u64_t COUNT_CEIL     = 64'hFFFF_FFFF;
  localparam int   WATCHDOG_LIMIT = 3000;
  localparam int   SETTLE_CYCLES  = 100;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [39:0]          s_tdata   = '0;  // site, value, uniform_draw
  logic                 s_tuser   = ACT_LOAD;  // action
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [95:0]          m_tdata;   // site_value, total_action, accept_total
  logic                 m_tuser;   // accepted
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_KINETIC;
  logic [COEFF_W-1:0]   cfg_data  = '0;

  metropolis_path_lattice_update_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Shadow copy of the lattice
  logic signed [15:0] ring_pos [RING_SIZE];
  logic [16:0]        exp_lut  [EXP_ENTRIES];
  u64_t               kin_k;
  u64_t               pot_k;
  u64_t               beta_k;
  u64_t               path_action;
  u64_t               accept_count;

  lattice_outcome_t pending_outcomes[$];
  int               mismatches   = 0;
  int               quiet_cycles = 0;
  int               hold_cycles  = 0;
  bit               idle_on      = 1'b1;

  // exp(-16 i / depth) in Q1.16: Taylor series of exp(-i/depth), then four squarings
  function automatic logic [16:0] exp_sample(int i);
    u64_t    u;
    u64_t    term;
    u64_t    e;
    longint  sum;
    u    = (u64_t'(i) << 30) / EXP_ENTRIES;
    sum  = longint'(1) << 30;
    term = u64_t'(1) << 30;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * u) >> 30) / u64_t'(n);
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    e = (sum < 0) ? 0 : u64_t'(sum);
    for (int k = 0; k < 4; k++) e = (e * e) >> 30;
    return 17'((e + 64'd8192) >> 14);
  endfunction

  function automatic void reset_lattice();
    kin_k        = KINETIC_RESET;
    pot_k        = POTENTIAL_RESET;
    beta_k       = INV_TEMP_RESET;
    path_action  = 0;
    accept_count = 0;
    for (int i = 0; i < RING_SIZE; i++) ring_pos[i] = '0;
    for (int i = 0; i < EXP_ENTRIES; i++) exp_lut[i] = exp_sample(i);
  endfunction

  function automatic u64_t bond_energy(int a, int b);
    longint d;
    longint s;
    u64_t   dd;
    u64_t   ss;
    d  = longint'(a) - longint'(b);
    s  = longint'(a) + longint'(b);
    dd = u64_t'(d * d);
    ss = u64_t'(s * s);
    return (64'd4 * kin_k * dd + pot_k * ss) >> 26;
  endfunction

  // Apply one accepted beat to the shadow lattice and queue the outcome
  function automatic void advance_lattice(action_t act, logic [7:0] site,
                                          logic [15:0] val, logic [15:0] draw);
    logic [7:0]       left;
    logic [7:0]       right;
    int               oldx;
    int               newx;
    int               lx;
    int               rx;
    u64_t             oldc;
    u64_t             newc;
    u64_t             arg;
    u64_t             idx;
    longint           delta;
    longint           t;
    bit               take;
    lattice_outcome_t o;
    left  = site - 8'd1;
    right = site + 8'd1;
    oldx  = ring_pos[site];
    lx    = ring_pos[left];
    rx    = ring_pos[right];
    take  = 1'b0;
    if (act == ACT_LOAD) begin
      newx = $signed(val);
      take = 1'b1;
    end else begin
      newx = oldx + $signed(val);
      if (newx > 32767) newx = 32767;
      if (newx < -32768) newx = -32768;
    end
    oldc  = bond_energy(lx, oldx) + bond_energy(oldx, rx);
    newc  = bond_energy(lx, newx) + bond_energy(newx, rx);
    delta = longint'(newc) - longint'(oldc);
    if (act == ACT_PROPOSE) begin
      if (delta < 0) begin
        take = 1'b1;
      end else begin
        arg  = (beta_k * u64_t'(delta)) >> 16;
        idx  = (arg * EXP_ENTRIES) / (u64_t'(16) << 16);
        take = (idx < EXP_ENTRIES) && (u64_t'(draw) < u64_t'(exp_lut[idx]));
      end
      if (take && accept_count < COUNT_CEIL) accept_count++;
    end
    if (take) begin
      t = longint'(path_action) + delta;
      if (t < 0) t = 0;
      if (u64_t'(t) > ACTION_CEIL) t = longint'(ACTION_CEIL);
      path_action    = u64_t'(t);
      ring_pos[site] = newx[15:0];
    end
    o.accepted     = take;
    o.site_value   = ring_pos[site];
    o.total_action = path_action[47:0];
    o.accept_total = accept_count[31:0];
    pending_outcomes.push_back(o);
  endfunction

  // Mostly back-to-back, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input action_t act, input logic [7:0] site,
                           input logic [15:0] val, input logic [15:0] draw);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {draw, val, site};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_lattice(act, site, val, draw);
  endtask

  // Drop valid on the beat just taken and wait for every outcome
  task automatic drain_outcomes();
    s_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [COEFF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_KINETIC:   kin_k  = val;
      CFG_POTENTIAL: pot_k  = val;
      CFG_INV_TEMP:  beta_k = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [COEFF_W-1:0] kin,
                                input logic [COEFF_W-1:0] pot,
                                input logic [COEFF_W-1:0] beta);
    drain_outcomes();
    write_register(CFG_KINETIC, kin);
    write_register(CFG_POTENTIAL, pot);
    write_register(CFG_INV_TEMP, beta);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_edges();
    send_item(ACT_LOAD,    8'd0,   16'h7FFF, 16'h0000);
    send_item(ACT_LOAD,    8'd255, 16'h8000, 16'hFFFF);
    send_item(ACT_LOAD,    8'd1,   16'h1000, 16'h5555);
    send_item(ACT_PROPOSE, 8'd128, 16'h0000, 16'hFFFF);  // no change, always taken
    send_item(ACT_PROPOSE, 8'd0,   16'h7FFF, 16'hFFFF);  // clips high
    send_item(ACT_PROPOSE, 8'd255, 16'h8000, 16'hFFFF);  // clips low
    send_item(ACT_PROPOSE, 8'd1,   16'hF000, 16'h0000);
    send_item(ACT_PROPOSE, 8'd10,  16'h7FFF, 16'h0000);  // far past the table
    send_item(ACT_PROPOSE, 8'd10,  16'h0100, 16'h0000);
    send_item(ACT_PROPOSE, 8'd10,  16'h0100, 16'hFFFF);
    send_item(ACT_PROPOSE, 8'd20,  16'h8000, 16'hFFFF);
    send_item(ACT_LOAD,    8'd10,  16'h0000, 16'hAAAA);
    send_item(ACT_PROPOSE, 8'd30,  16'h5555, 16'h8000);
    send_item(ACT_PROPOSE, 8'd31,  16'hAAAA, 16'h7FFF);
    send_item(ACT_PROPOSE, 8'd254, 16'h0001, 16'h0001);
    send_item(ACT_PROPOSE, 8'd128, 16'hFFFF, 16'hFFFE);
  endtask

  // Stale total plus a large negative change must floor at zero
  task automatic test_action_floor();
    apply_settings(24'd1, 24'd0, INV_TEMP_RESET);
    send_item(ACT_LOAD, 8'd50, 16'h7FFF, 16'h0000);
    send_item(ACT_LOAD, 8'd52, 16'h8000, 16'h0000);
    apply_settings(24'hFFFFFF, 24'hFFFFFF, INV_TEMP_RESET);
    send_item(ACT_LOAD, 8'd50, 16'h0000, 16'h0000);
    send_item(ACT_LOAD, 8'd52, 16'h0000, 16'h0000);
    send_item(ACT_PROPOSE, 8'd50, 16'h0000, 16'hFFFF);
  endtask

  task automatic send_random_item(input logic [7:0] base);
    int          r;
    int          pert;
    logic [7:0]  site;
    logic [15:0] val;
    site = ($urandom_range(0, 1) == 0) ? base + 8'($urandom_range(0, 7))
                                       : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 20) begin
      val = 16'($urandom_range(0, 65535));
      send_item(ACT_LOAD, site, val, 16'($urandom_range(0, 65535)));
    end else begin
      if (r < 76) begin
        pert = $urandom_range(0, 8191);
        val  = 16'(pert - 4096);
      end else begin
        val = 16'($urandom_range(0, 65535));
      end
      send_item(ACT_PROPOSE, site, val, 16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic test_random_phase(input logic [COEFF_W-1:0] kin,
                                   input logic [COEFF_W-1:0] pot,
                                   input logic [COEFF_W-1:0] beta,
                                   input int count, input bit with_idle);
    logic [7:0] base;
    apply_settings(kin, pot, beta);
    idle_on = with_idle;
    base = 8'($urandom_range(0, 255));
    for (int i = 0; i < count; i++) begin
      // move the hot window now and then
      if (i % 40 == 39) base = 8'($urandom_range(0, 255));
      send_random_item(base);
    end
    drain_outcomes();
    idle_on = 1'b1;
  endtask

  task automatic test_random_sweeps();
    test_random_phase(KINETIC_RESET, POTENTIAL_RESET, INV_TEMP_RESET, 220, 1'b0);
    test_random_phase(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 200, 1'b1);
    test_random_phase(24'd0, 24'd0, 24'd0, 180, 1'b1);
    test_random_phase(24'($urandom_range(1024, 262143)), 24'($urandom_range(1024, 262143)),
                      24'($urandom_range(0, 24'h7FFFF)), 240, 1'b1);
    test_random_phase(24'd4096, 24'd4096, 24'd1048576, 230, 1'b1);
    test_random_phase(KINETIC_RESET, 24'd0, 24'd4096, 230, 1'b1);
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready    <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      hold_cycles <= pick_gap();
      m_tready    <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_outcomes
    lattice_outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outcomes.size() == 0) begin
        $error("result beat with no outcome pending");
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        if (m_tuser !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, m_tuser);
          mismatches++;
        end
        if (m_tdata[15:0] !== want.site_value) begin
          $error("site_value: expected %0d, got %0d",
                 $signed(want.site_value), $signed(m_tdata[15:0]));
          mismatches++;
        end
        if (m_tdata[63:16] !== want.total_action) begin
          $error("total_action: expected %0d, got %0d", want.total_action, m_tdata[63:16]);
          mismatches++;
        end
        if (m_tdata[95:64] !== want.accept_total) begin
          $error("accept_total: expected %0d, got %0d", want.accept_total, m_tdata[95:64]);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run: count cycles with no beat on any channel
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    reset_lattice();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_action_floor();
    test_random_sweeps();
    drain_outcomes();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- metropolis_path_lattice_update_unit.f -----
sv/mplu_pkg.sv
sv/mplu_path_mem.sv
sv/mplu_exp_rom.sv
sv/mplu_mul.sv
sv/metropolis_path_lattice_update_unit.sv
sim/metropolis_path_lattice_update_unit_tb.sv
